>>> hw/rtl/mctt_pkg.sv
// shared types and constants of the timer table
`default_nettype none
package mctt_pkg;

    localparam int TW = 31;
    localparam int IDW = 8;
    localparam logic [TW-1:0] NEVER = {TW{1'b1}};
    localparam logic [TW-1:0] CAP_RESET = TW'(10 * 1000);
    localparam int MAX_RESULTS = 16;

    typedef enum logic [2:0] {
        OP_ADD_PER  = 3'd0,
        OP_ADD_ONE  = 3'd1,
        OP_SET_IVL  = 3'd2,
        OP_SET_DLY  = 3'd3,
        OP_REMOVE   = 3'd4,
        OP_TICK     = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_FIRED    = 3'd1,
        ST_NOT_FND  = 3'd2,
        ST_DUP      = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef struct packed {
        logic [2:0]    opcode;
        logic [IDW-1:0] timer_id;
        logic [TW-1:0] interval_ms;
        logic [TW-1:0] delay_ms;
        logic [TW-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic [2:0]     status;
        logic [IDW-1:0] fired_id;
        logic [TW-1:0]  min_interval_ms;
        logic           tick_needed;
        logic           last;
    } result_t;

    // saturating add of two 31-bit times
    function automatic logic [TW-1:0] sat_add(input logic [TW-1:0] a,
                                              input logic [TW-1:0] b);
        logic [TW:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = (s >= {1'b0, NEVER}) ? NEVER : s[TW-1:0];
    endfunction

endpackage
`default_nettype wire

>>> hw/rtl/mctt_if.sv
// valid/ready channel interfaces
`default_nettype none
interface mctt_item_if import mctt_pkg::*; ();
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mctt_result_if import mctt_pkg::*; ();
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mctt_cfg_if import mctt_pkg::*; ();
    logic          valid;
    logic          ready;
    logic [TW-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/multi_channel_timer_table.sv
// top level of the timer table
// Each transaction is handled alone. Every operation walks the slot memory one slot a cycle
// through its single registered read port. A non-tick transaction then applies its change
// and emits one result, and a new transaction is accepted only after that result has been
// taken; a remove that takes away the current minimum walks the table once more to recompute
// it. A tick walks the table once for each timer that fires, up to 16 firings, and once when
// nothing is due. A stall of the result sink holds the block. Results go out through an
// output register; configuration writes are taken at any time and must only be made while
// the block is idle.
`default_nettype none
module multi_channel_timer_table import mctt_pkg::*; #(
    parameter int SLOTS = 16
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    mctt_item_if.sink    in_ch,
    mctt_result_if.source out_ch,
    mctt_cfg_if.sink     cfg
);
    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int NW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_APPLY = 7'b0000100,
        S_RESC  = 7'b0001000,
        S_EMIT  = 7'b0010000,
        S_MINR  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    item_t          item_reg;
    logic [TW-1:0]  cap_reg;
    logic [TW-1:0]  min_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [CW-1:0]  cnt_reg;        // address issued
    logic           rd_pend_reg;    // read data of slot rd_slot_reg arrives this cycle
    logic [AW-1:0]  rd_slot_reg;
    logic           hit_reg;
    logic           more_reg;       // a second due slot was seen in this walk
    logic [AW-1:0]  hit_slot_reg;
    logic [IDW-1:0] hit_id_reg;
    logic [TW-1:0]  hit_ivl_reg;
    logic [TW-1:0]  hit_due_reg;
    logic           free_ok_reg;
    logic [AW-1:0]  free_slot_reg;
    logic [TW-1:0]  scan_min_reg;
    logic [NW-1:0]  fired_reg;
    logic           out_valid_reg;
    result_t        out_reg;

    logic [AW-1:0]  rd_addr;
    logic [IDW-1:0] rd_id;
    logic [TW-1:0]  rd_ivl, rd_due;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [IDW-1:0] wr_id;
    logic [TW-1:0]  wr_ivl, wr_due;

    mctt_slot_mem #(.SLOTS(SLOTS), .AW(AW)) u_mem (
        .clk(clk), .rd_addr(rd_addr), .rd_id(rd_id), .rd_ivl(rd_ivl), .rd_due(rd_due),
        .wr_en(wr_en), .wr_addr(wr_addr), .wr_id(wr_id), .wr_ivl(wr_ivl), .wr_due(wr_due)
    );

    logic [TW-1:0] ivl_in;
    logic [TW-1:0] eff_min;
    logic          op_tick, op_rem, op_add;
    logic          scan_done;
    logic          cur_v;

    assign ivl_in    = (item_reg.interval_ms == NEVER) ? NEVER - TW'(1) : item_reg.interval_ms;
    assign eff_min   = (min_reg < cap_reg) ? min_reg : cap_reg;
    assign op_tick   = item_reg.opcode == OP_TICK;
    assign op_rem    = item_reg.opcode == OP_REMOVE;
    assign op_add    = item_reg.opcode == OP_ADD_PER || item_reg.opcode == OP_ADD_ONE;
    assign rd_addr   = cnt_reg[AW-1:0];
    assign scan_done = (cnt_reg == CW'(SLOTS)) && !rd_pend_reg;
    assign cur_v     = valid_reg[rd_slot_reg];

    assign in_ch.ready   = state_reg == S_IDLE;
    assign cfg.ready     = 1'b1;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.data   = out_reg;

    // write port
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = hit_slot_reg;
        wr_id   = hit_id_reg;
        wr_ivl  = hit_ivl_reg;
        wr_due  = hit_due_reg;
        if (state_reg == S_APPLY)
        begin
            case (item_reg.opcode)
                OP_ADD_PER, OP_ADD_ONE:
                begin
                    wr_en   = !hit_reg && free_ok_reg;
                    wr_addr = free_slot_reg;
                    wr_id   = item_reg.timer_id;
                    wr_ivl  = (item_reg.opcode == OP_ADD_ONE) ? NEVER : ivl_in;
                    wr_due  = sat_add(item_reg.now_ms, item_reg.delay_ms);
                end
                OP_SET_IVL:
                begin
                    wr_en  = hit_reg;
                    wr_ivl = ivl_in;
                end
                OP_SET_DLY:
                begin
                    wr_en  = hit_reg;
                    wr_due = sat_add(item_reg.now_ms, item_reg.delay_ms);
                end
                default:
                begin
                    wr_en = 1'b0;
                end
            endcase
        end
        else if (state_reg == S_RESC)
        begin
            wr_en  = 1'b1;
            wr_due = (hit_ivl_reg == NEVER) ? NEVER : sat_add(item_reg.now_ms, hit_ivl_reg);
        end
    end

    // state transitions
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (in_ch.valid) state_next = S_SCAN;
            S_SCAN:  if (scan_done) state_next = op_tick ? (hit_reg ? S_RESC : S_EMIT) : S_APPLY;
            S_APPLY: state_next = (op_rem && hit_reg && hit_ivl_reg == min_reg) ? S_MINR : S_EMIT;
            S_RESC:  state_next = S_EMIT;
            S_MINR:  if (scan_done) state_next = S_EMIT;
            S_EMIT:  if (!out_valid_reg || out_ch.ready) state_next = S_WAIT;
            S_WAIT:
            begin
                if (!out_valid_reg || out_ch.ready)
                begin
                    if (op_tick && hit_reg && !out_reg.last)
                        state_next = S_SCAN;
                    else
                        state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cap_reg       <= CAP_RESET;
            min_reg       <= CAP_RESET;
            valid_reg     <= '0;
            cnt_reg       <= '0;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            more_reg      <= 1'b0;
            free_ok_reg   <= 1'b0;
            fired_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
            begin
                cap_reg <= cfg.data;
            end
            if (out_valid_reg && out_ch.ready && state_reg != S_EMIT)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    cnt_reg     <= '0;
                    rd_pend_reg <= 1'b0;
                    hit_reg     <= 1'b0;
                    more_reg    <= 1'b0;
                    free_ok_reg <= 1'b0;
                    fired_reg   <= '0;
                end
                S_SCAN, S_MINR:
                begin
                    // walk one slot a cycle
                    rd_pend_reg <= cnt_reg != CW'(SLOTS);
                    if (cnt_reg != CW'(SLOTS))
                    begin
                        cnt_reg <= cnt_reg + CW'(1);
                    end
                    if (rd_pend_reg && cur_v)
                    begin
                        if (state_reg == S_MINR)
                        begin
                            if (rd_ivl < scan_min_reg) scan_min_reg <= rd_ivl;
                        end
                        else if (op_tick)
                        begin
                            if (rd_due < item_reg.now_ms)
                            begin
                                if (hit_reg)
                                begin
                                    more_reg <= 1'b1;
                                end
                                if (!hit_reg || rd_due < hit_due_reg)
                                begin
                                    hit_reg <= 1'b1;
                                    hit_slot_reg <= rd_slot_reg;
                                    hit_id_reg <= rd_id;
                                    hit_ivl_reg <= rd_ivl;
                                    hit_due_reg <= rd_due;
                                end
                            end
                        end
                        else if (!hit_reg && rd_id == item_reg.timer_id)
                        begin
                            hit_reg <= 1'b1;
                            hit_slot_reg <= rd_slot_reg;
                            hit_id_reg <= rd_id;
                            hit_ivl_reg <= rd_ivl;
                            hit_due_reg <= rd_due;
                        end
                    end
                    else if (rd_pend_reg && state_reg == S_SCAN && !free_ok_reg)
                    begin
                        free_ok_reg   <= 1'b1;
                        free_slot_reg <= rd_slot_reg;
                    end
                    if (state_reg == S_MINR && scan_done)
                    begin
                        min_reg <= scan_min_reg;
                    end
                end
                S_APPLY:
                begin
                    cnt_reg      <= '0;
                    rd_pend_reg  <= 1'b0;
                    scan_min_reg <= cap_reg;
                    if (op_add && !hit_reg && free_ok_reg)
                    begin
                        valid_reg[free_slot_reg] <= 1'b1;
                        if (item_reg.opcode == OP_ADD_PER && ivl_in < min_reg) min_reg <= ivl_in;
                    end
                    if (item_reg.opcode == OP_SET_IVL && hit_reg && hit_ivl_reg != ivl_in
                        && ivl_in < min_reg)
                    begin
                        min_reg <= ivl_in;
                    end
                    if (op_rem && hit_reg)
                    begin
                        valid_reg[hit_slot_reg] <= 1'b0;
                    end
                end
                S_RESC:
                begin
                    fired_reg <= fired_reg + NW'(1);
                end
                S_EMIT:
                begin
                    if (!out_valid_reg || out_ch.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg.min_interval_ms <= eff_min;
                        out_reg.tick_needed <= min_reg < cap_reg;
                        if (op_tick && hit_reg)
                        begin
                            out_reg.status   <= ST_FIRED;
                            out_reg.fired_id <= hit_id_reg;
                            out_reg.last     <= fired_reg == NW'(MAX_RESULTS) || !more_reg;
                        end
                        else
                        begin
                            out_reg.fired_id <= '0;
                            out_reg.last     <= 1'b1;
                            if (op_tick || !(op_add || item_reg.opcode == OP_SET_IVL ||
                                item_reg.opcode == OP_SET_DLY || op_rem))
                                out_reg.status <= ST_OK;
                            else if (op_add)
                                out_reg.status <= hit_reg ? ST_DUP
                                                 : (free_ok_reg ? ST_OK : ST_FULL);
                            else
                                out_reg.status <= hit_reg ? ST_OK : ST_NOT_FND;
                        end
                    end
                end
                S_WAIT:
                begin
                    // a tick with further slots due, below the result limit, walks the table again
                    cnt_reg     <= '0;
                    rd_pend_reg <= 1'b0;
                    if (state_next == S_SCAN)
                    begin
                        hit_reg  <= 1'b0;
                        more_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
            rd_slot_reg <= rd_addr;
            if (state_reg == S_IDLE && in_ch.valid)
            begin
                item_reg <= in_ch.data;
            end
        end
    end

    // checks
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.ready |-> !out_valid_reg || out_ch.ready || state_reg == S_IDLE)
        else $error("ready outside idle");
    a_fire_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        fired_reg <= NW'(MAX_RESULTS))
        else $error("too many firings");
    a_emit_once: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && (!out_valid_reg || out_ch.ready) |=> out_valid_reg)
        else $error("result lost");
endmodule
`default_nettype wire

>>> hw/rtl/mctt_slot_mem.sv
// slot memory: id, interval and due time, one read and one write port
`default_nettype none
module mctt_slot_mem import mctt_pkg::*; #(
    parameter int SLOTS = 16,
    parameter int AW = 4
) (
    input  wire logic                clk,
    input  wire logic [AW-1:0]       rd_addr,
    output logic [IDW-1:0]           rd_id,
    output logic [TW-1:0]            rd_ivl,
    output logic [TW-1:0]            rd_due,
    input  wire logic                wr_en,
    input  wire logic [AW-1:0]       wr_addr,
    input  wire logic [IDW-1:0]      wr_id,
    input  wire logic [TW-1:0]       wr_ivl,
    input  wire logic [TW-1:0]       wr_due
);
    logic [IDW+2*TW-1:0] mem [SLOTS];

    // synchronous write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_id, wr_ivl, wr_due};
        end
    end

    // registered read
    always_ff @(posedge clk)
    begin
        {rd_id, rd_ivl, rd_due} <= mem[rd_addr];
    end
endmodule
`default_nettype wire
